@@ rtl/rcp_pkg.sv @@
// ----------------------------------------------------------------------------
// rcp_pkg
// Shared types and constants for the read coverage pileup unit.
// ----------------------------------------------------------------------------
package rcp_pkg;

  localparam int PosW     = 21;
  localparam int ExtW     = 13;
  localparam int ChromW   = 21;
  localparam int OutCntW  = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 21;

  localparam int MaxPositionsDef = 1048576;
  localparam int CountWidthDef   = 16;

  localparam logic [ExtW-1:0]   ExtendReset = ExtW'(200);
  localparam logic [ChromW-1:0] ChromReset  = ChromW'(1048576);

  localparam logic [CfgIdxW-1:0] CFG_EXTEND_LENGTH = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_CHROM_LENGTH  = CfgIdxW'(1);

  typedef enum logic {
    OP_ADD_READ   = 1'b0,
    OP_READ_CLEAR = 1'b1
  } rcp_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_RC_WAIT,
    ST_RC_WB
  } rcp_state_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;   // zero one entry of the post-reset sweep
    logic load;       // capture the accepted word
    logic rd_add;     // read for increment, advance address
    logic rd_clr;     // read for read_clear
    logic out_bad;    // load an out-of-range result
    logic out_data;   // load read data as result, zero the entry
  } rcp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_done;
    logic pos_ok;     // position of the offered word is in range
    logic ext_zero;
    logic last;       // last entry of the current add_read walk
    logic item_ok;    // registered pos_ok of the captured word
    logic out_free;
  } rcp_status_t;

endpackage

@@ rtl/read_coverage_pileup_unit.sv @@
// ----------------------------------------------------------------------------
// read_coverage_pileup_unit
// Per-base coverage pileup over one chromosome with a saturating count store.
// ----------------------------------------------------------------------------
// Input words (in_valid_i / in_stall_o): opcode_i 0 adds a read starting at
// position_i covering extend_length bases (clipped to chrom_length, capped at
// MAX_POSITIONS); opcode_i 1 returns the count at position_i and zeroes it.
// Output words (out_valid_o / out_stall_i) carry coverage_count_o and
// out_of_range_o, one per read_clear, none per add_read.
// An add_read walks the bases it covers: the store has one read and one write
// port, so the walk does one read-modify-write per cycle. A read_clear reads
// the store in ST_RC_WAIT, then loads the result and zeroes the entry in
// ST_RC_WB; an out-of-range one loads its result from ST_RC_WAIT. Reset runs
// a clearing sweep over the store with in_stall_o high; config writes are
// taken during it. While the receiver stalls, the result word is held; the
// next add_read is still accepted, a following read_clear waits until the
// output register frees up.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 extend_length, 1 chrom_length); write only while the unit is idle.
// ----------------------------------------------------------------------------
module read_coverage_pileup_unit #(
  parameter int MAX_POSITIONS = rcp_pkg::MaxPositionsDef,
  parameter int COUNT_WIDTH   = rcp_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [rcp_pkg::PosW-1:0]      position_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rcp_pkg::OutCntW-1:0]   coverage_count_o,
  output logic                          out_of_range_o
);
  import rcp_pkg::*;

  rcp_cmd_t    cmd;
  rcp_status_t status;

  rcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  rcp_dpath #(
    .MaxPositions (MAX_POSITIONS),
    .CountWidth   (COUNT_WIDTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .position_i       (position_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .coverage_count_o (coverage_count_o),
    .out_of_range_o   (out_of_range_o)
  );

endmodule

@@ rtl/rcp_ram.sv @@
// ----------------------------------------------------------------------------
// rcp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rcp_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/rcp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcp_ctrl
// Sequencer: clearing sweep, add_read walk and read_clear access.
// ----------------------------------------------------------------------------
module rcp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 opcode_i,
  input  rcp_pkg::rcp_status_t status_i,
  output rcp_pkg::rcp_cmd_t    cmd_o,
  output logic                 in_stall_o
);
  import rcp_pkg::*;

  rcp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (opcode_i == OP_READ_CLEAR) begin
            state_d = ST_RC_WAIT;
          end else if (status_i.pos_ok && !status_i.ext_zero) begin
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        cmd_o.rd_add = 1'b1;
        if (status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RC_WAIT: begin
        // hold until the output register can take a word
        if (status_i.out_free) begin
          if (status_i.item_ok) begin
            cmd_o.rd_clr = 1'b1;
            state_d      = ST_RC_WB;
          end else begin
            cmd_o.out_bad = 1'b1;
            state_d       = ST_IDLE;
          end
        end
      end
      ST_RC_WB: begin
        cmd_o.out_data = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rcp_dpath.sv @@
// ----------------------------------------------------------------------------
// rcp_dpath
// Config registers, address/length counters, count store and output register.
// ----------------------------------------------------------------------------
module rcp_dpath #(
  parameter int MaxPositions = rcp_pkg::MaxPositionsDef,
  parameter int CountWidth   = rcp_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rcp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic [rcp_pkg::PosW-1:0]      position_i,
  input  logic                          out_stall_i,
  input  rcp_pkg::rcp_cmd_t             cmd_i,
  output rcp_pkg::rcp_status_t          status_o,
  output logic                          out_valid_o,
  output logic [rcp_pkg::OutCntW-1:0]   coverage_count_o,
  output logic                          out_of_range_o
);
  import rcp_pkg::*;

  localparam int AddrW = $clog2(MaxPositions);
  localparam int LenW  = ($clog2(MaxPositions + 1) > PosW) ? $clog2(MaxPositions + 1) : PosW;

  logic [ExtW-1:0]   extend_q;
  logic [ChromW-1:0] chrom_q;

  logic [AddrW-1:0]  addr_q, addr_d;
  logic [AddrW-1:0]  wr_addr_q;
  logic              inc_pend_q;
  logic [ExtW-1:0]   n_q, n_d;
  logic              item_ok_q;

  logic              out_valid_q;
  logic [OutCntW-1:0] count_q;
  logic              oor_q;

  logic [LenW-1:0]   eff_len;
  logic [LenW-1:0]   pos_ext;
  logic [LenW-1:0]   pos_m1;
  logic [LenW-1:0]   avail;
  logic [LenW-1:0]   ext_ext;
  logic              pos_ok;

  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [CountWidth-1:0] ram_wdata;
  logic                  ram_re;
  logic [CountWidth-1:0] ram_rdata;
  logic [CountWidth-1:0] cnt_inc;
  logic [CountWidth+OutCntW-1:0] rd_wide;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extend_q <= ExtendReset;
      chrom_q  <= ChromReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_EXTEND_LENGTH: extend_q <= cfg_wdata_i[ExtW-1:0];
        CFG_CHROM_LENGTH:  chrom_q  <= cfg_wdata_i[ChromW-1:0];
        default: ;
      endcase
    end
  end

  // range check and walk length of the offered word
  always_comb begin
    eff_len = (LenW'(chrom_q) < LenW'(MaxPositions)) ? LenW'(chrom_q) : LenW'(MaxPositions);
    pos_ext = LenW'(position_i);
    pos_m1  = pos_ext - LenW'(1);
    pos_ok  = (position_i != '0) && (pos_ext <= eff_len);
    avail   = eff_len - pos_m1;
    ext_ext = LenW'(extend_q);
    n_d     = (avail < ext_ext) ? avail[ExtW-1:0] : extend_q;
  end

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load) begin
      addr_d = pos_m1[AddrW-1:0];
    end else if (cmd_i.clr_step || cmd_i.rd_add) begin
      addr_d = addr_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      inc_pend_q <= 1'b0;
      n_q        <= '0;
      item_ok_q  <= 1'b0;
    end else begin
      addr_q     <= addr_d;
      inc_pend_q <= cmd_i.rd_add;
      if (cmd_i.load) begin
        n_q       <= n_d;
        item_ok_q <= pos_ok;
      end else if (cmd_i.rd_add) begin
        n_q <= n_q - ExtW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_add || cmd_i.rd_clr) begin
      wr_addr_q <= addr_q;
    end
  end

  // store: read one cycle, write back the next
  always_comb begin
    cnt_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + CountWidth'(1);
    ram_re    = cmd_i.rd_add || cmd_i.rd_clr;
    ram_we    = cmd_i.clr_step || inc_pend_q || cmd_i.out_data;
    ram_waddr = cmd_i.clr_step ? addr_q : wr_addr_q;
    ram_wdata = inc_pend_q ? cnt_inc : '0;
    rd_wide   = {{OutCntW{1'b0}}, ram_rdata};
  end

  rcp_ram #(
    .Width (CountWidth),
    .Depth (MaxPositions)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_bad || cmd_i.out_data) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_bad) begin
      count_q <= '0;
      oor_q   <= 1'b1;
    end else if (cmd_i.out_data) begin
      count_q <= rd_wide[OutCntW-1:0];
      oor_q   <= 1'b0;
    end
  end

  always_comb begin
    status_o.clr_done = (addr_q == AddrW'(MaxPositions - 1));
    status_o.pos_ok   = pos_ok;
    status_o.ext_zero = (extend_q == '0);
    status_o.last     = (n_q == ExtW'(1));
    status_o.item_ok  = item_ok_q;
    status_o.out_free = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o      = out_valid_q;
  assign coverage_count_o = count_q;
  assign out_of_range_o   = oor_q;

endmodule

@@ rtl/rcp_checker.sv @@
// ----------------------------------------------------------------------------
// rcp_checker
// Port-level checks for the read coverage pileup unit.
// ----------------------------------------------------------------------------
module rcp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        opcode_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [rcp_pkg::OutCntW-1:0] coverage_count_o,
  input logic                        out_of_range_o
);
  import rcp_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coverage_count_o)
      && $stable(out_of_range_o))
    else $error("result word changed while stalled");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> coverage_count_o == '0)
    else $error("out-of-range word with nonzero count");

  // clearing sweep blocks input right after reset
  a_sweep_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input taken during clearing sweep");

  a_rc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == OP_READ_CLEAR |=> in_stall_o)
    else $error("input not stalled during read_clear");

endmodule

bind read_coverage_pileup_unit rcp_checker u_rcp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .opcode_i         (opcode_i),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .coverage_count_o (coverage_count_o),
  .out_of_range_o   (out_of_range_o)
);
